// ===== rtl/vmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector-matrix multiply package
// Shared sizes, command codes, controller states and the command word that
// the controller hands to the datapath.
// ----------------------------------------------------------------------------
package vmm_pkg;

    localparam int MAX_SIZE    = 32;
    localparam int VALUE_BITS  = 16;

    localparam int IDX_W       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int N_W         = $clog2(MAX_SIZE + 1);
    localparam int MAT_DEPTH   = MAX_SIZE * MAX_SIZE;
    localparam int MAT_AW      = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int PROD_W      = 2 * VALUE_BITS;
    localparam int ACC_W       = 40;

    // Fixed widths of the interface fields.
    localparam int CMD_W       = 2;
    localparam int FIELD_IDX_W = 5;
    localparam int VALUE_W     = 16;
    localparam int COL_W       = 5;
    localparam int CFG_W       = 6;
    localparam int CFG_RESET   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_MAT_WR  = 2'd0,
        CMD_VEC_WR  = 2'd1,
        CMD_COMPUTE = 2'd2
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic             mat_we;
        logic             vec_we;
        logic             mac;
        logic             first;
        logic             last_j;
        logic             last_col;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] col;
    } t_dp_cmd;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_j;
        logic             last_col;
        logic [IDX_W-1:0] col;
    } t_mac_tag;

endpackage

// ===== rtl/vmm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module vmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Vector-matrix multiply controller
// Holds the size register, decodes commands and steps the row and column
// counters through one multiply-accumulate per cycle during a compute.
// ----------------------------------------------------------------------------
module vmm_ctrl import vmm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CMD_W-1:0] i_command,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output logic             o_busy,
    output t_dp_cmd          o_dp_cmd
);

    t_state           r_state;
    t_state           n_state;
    logic [CFG_W-1:0] r_size;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_col;
    logic [IDX_W-1:0] r_last;

    logic             w_accept;
    logic             w_compute;
    logic [N_W-1:0]   w_n;
    logic             w_last_mac;

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_compute  = (i_command == CMD_COMPUTE);
    // A size above the matrix capacity is treated as the full matrix.
    assign w_n        = (int'(r_size) > MAX_SIZE) ? N_W'(MAX_SIZE) : N_W'(r_size);
    assign w_last_mac = (r_j == r_last) && (r_col == r_last);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_compute && (w_n != '0)) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_last_mac) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_busy            = (r_state == S_RUN);
        o_dp_cmd.mat_we   = w_accept && (i_command == CMD_MAT_WR);
        o_dp_cmd.vec_we   = w_accept && (i_command == CMD_VEC_WR);
        o_dp_cmd.mac      = (r_state == S_RUN);
        o_dp_cmd.first    = (r_j == '0);
        o_dp_cmd.last_j   = (r_j == r_last);
        o_dp_cmd.last_col = (r_col == r_last);
        o_dp_cmd.j        = r_j;
        o_dp_cmd.col      = r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= CFG_W'(CFG_RESET);
            r_j     <= '0;
            r_col   <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (r_state == S_IDLE) begin
                if (w_accept && w_compute) begin
                    r_j    <= '0;
                    r_col  <= '0;
                    r_last <= IDX_W'(w_n - N_W'(1));
                end
            end else if (r_j == r_last) begin
                r_j   <= '0;
                r_col <= r_col + IDX_W'(1);
            end else begin
                r_j <= r_j + IDX_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && w_last_mac |=> (r_state == S_IDLE))
        else $error("compute did not finish after its last multiply-accumulate");

    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_j == r_last) && (r_col != r_last)
        |=> (r_j == '0) && (r_col == $past(r_col) + IDX_W'(1)))
        else $error("column counter did not advance at the end of a column");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_compute && (w_n == '0) |=> (r_state == S_IDLE))
        else $error("a compute of size zero started a run");
`endif

endmodule

// ===== rtl/vmm_datapath.sv =====
// ----------------------------------------------------------------------------
// Vector-matrix multiply datapath
// Matrix and vector RAMs, one multiplier and the 40-bit accumulator, with
// a tag pipeline that follows each multiply-accumulate to the result port.
// ----------------------------------------------------------------------------
module vmm_datapath import vmm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_dp_cmd,
    input  logic [FIELD_IDX_W-1:0]    i_row_index,
    input  logic [FIELD_IDX_W-1:0]    i_col_index,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_result_strobe,
    output logic [COL_W-1:0]          o_column_index,
    output logic signed [ACC_W-1:0]   o_result_value,
    output logic                      o_last
);

    logic signed [VALUE_BITS-1:0] w_wval;
    logic                         w_row_ok;
    logic                         w_col_ok;
    logic [MAT_AW-1:0]            w_mat_waddr;
    logic [MAT_AW-1:0]            w_mat_raddr;
    logic [VALUE_BITS-1:0]        w_mat_q;
    logic [VALUE_BITS-1:0]        w_vec_q;
    logic signed [VALUE_BITS-1:0] w_mat_s;
    logic signed [VALUE_BITS-1:0] w_vec_s;
    logic signed [ACC_W-1:0]      w_prod_ext;
    logic signed [ACC_W-1:0]      w_sum;

    t_mac_tag                     r_tag1;
    t_mac_tag                     r_tag2;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]      r_acc;
    logic                         r_strobe;
    logic [COL_W-1:0]             r_column;
    logic signed [ACC_W-1:0]      r_result;
    logic                         r_last;

    // Entries are kept in VALUE_BITS bits; the signed cast sign-extends or trims.
    assign w_wval      = VALUE_BITS'(i_value);
    assign w_row_ok    = int'(i_row_index) < MAX_SIZE;
    assign w_col_ok    = int'(i_col_index) < MAX_SIZE;
    assign w_mat_waddr = MAT_AW'(int'(i_row_index) * MAX_SIZE + int'(i_col_index));
    assign w_mat_raddr = MAT_AW'(int'(i_dp_cmd.j) * MAX_SIZE + int'(i_dp_cmd.col));

    vmm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAT_DEPTH)
    ) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (i_dp_cmd.mat_we && w_row_ok && w_col_ok),
        .i_waddr (w_mat_waddr),
        .i_wdata (w_wval),
        .i_raddr (w_mat_raddr),
        .o_rdata (w_mat_q)
    );

    vmm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_SIZE)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (i_dp_cmd.vec_we && w_row_ok),
        .i_waddr (IDX_W'(i_row_index)),
        .i_wdata (w_wval),
        .i_raddr (i_dp_cmd.j),
        .o_rdata (w_vec_q)
    );

    assign w_mat_s    = w_mat_q;
    assign w_vec_s    = w_vec_q;
    assign w_prod_ext = ACC_W'(r_prod);
    // The first product of a column restarts the sum.
    assign w_sum      = r_tag2.first ? w_prod_ext : r_acc + w_prod_ext;

    always_ff @(posedge i_clk) begin
        r_tag1.first    <= i_dp_cmd.first;
        r_tag1.last_j   <= i_dp_cmd.last_j;
        r_tag1.last_col <= i_dp_cmd.last_col;
        r_tag1.col      <= i_dp_cmd.col;
        r_tag2.first    <= r_tag1.first;
        r_tag2.last_j   <= r_tag1.last_j;
        r_tag2.last_col <= r_tag1.last_col;
        r_tag2.col      <= r_tag1.col;
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            r_acc        <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_tag1.valid <= i_dp_cmd.mac;
            r_tag2.valid <= r_tag1.valid;
            if (r_tag2.valid) begin
                r_acc <= w_sum;
            end
            r_strobe <= r_tag2.valid && r_tag2.last_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_vec_s * w_mat_s;
        if (r_tag2.valid && r_tag2.last_j) begin
            r_column <= COL_W'(r_tag2.col);
            r_result <= w_sum;
            r_last   <= r_tag2.last_col;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_column_index  = r_column;
    assign o_result_value  = r_result;
    assign o_last          = r_last;

`ifndef NO_ASSERTIONS
    a_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag2.valid && !r_tag2.first |-> $past(r_tag2.valid))
        else $error("accumulation continued across a gap in the product stream");
`endif

endmodule

// ===== rtl/vector_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// Vector-matrix multiply
// Row vector times square matrix with signed 16-bit entries and exact
// 40-bit results, one result word per column.
// ----------------------------------------------------------------------------
// A load word (matrix or vector entry) is taken at once, so loads may
// follow each other back to back. A compute word keeps busy high through
// its n*n multiply-accumulates, n being the size in use capped at 32: one
// per cycle through a single multiplier fed from one read port of the
// matrix RAM and one of the vector RAM. Each column's result word leaves on
// o_result_strobe via the RAM read, product and result registers, in column
// order, and o_last marks the final column. The receiver cannot stall the
// results; a new word may be started once busy is low, while the last
// results are on their way out. A compute of size zero gives no result word.
// The user must write the size register only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module vector_matrix_multiply import vmm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [CMD_W-1:0]          i_command,
    input  logic [FIELD_IDX_W-1:0]    i_row_index,
    input  logic [FIELD_IDX_W-1:0]    i_col_index,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_wdata,
    output logic                      o_result_strobe,
    output logic [COL_W-1:0]          o_column_index,
    output logic signed [ACC_W-1:0]   o_result_value,
    output logic                      o_last
);

    t_dp_cmd w_dp_cmd;

    vmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_command   (i_command),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_busy      (busy),
        .o_dp_cmd    (w_dp_cmd)
    );

    vmm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (w_dp_cmd),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_value         (i_value),
        .o_result_strobe (o_result_strobe),
        .o_column_index  (o_column_index),
        .o_result_value  (o_result_value),
        .o_last          (o_last)
    );

endmodule

// ===== verif/vector_matrix_multiply_test.sv =====
// ----------------------------------------------------------------------------
// Vector-matrix multiply testbench
// Loads matrix and vector entries, runs computes at many sizes and checks
// every column result word against a predictor of the multiply held in a
// small scoreboard class.
// ----------------------------------------------------------------------------
module vector_matrix_multiply_test;
    import vmm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [COL_W-1:0]        column;
        logic signed [ACC_W-1:0] product;
        logic                    last;
    } t_column_result;

    class product_ledger;
        logic signed [VALUE_W-1:0] matrix [MAX_SIZE][MAX_SIZE];
        logic signed [VALUE_W-1:0] vector [MAX_SIZE];
        int                        size_in_use = CFG_RESET;
        t_column_result            awaited [$];
        int                        errors = 0;
        int                        columns_checked = 0;
        int                        computes = 0;

        function void set_size(int value);
            size_in_use = value;
        endfunction

        // Predicts the column results that an accepted word causes.
        function void note_word(logic [CMD_W-1:0] cmd, logic [FIELD_IDX_W-1:0] row,
                                logic [FIELD_IDX_W-1:0] col,
                                logic signed [VALUE_W-1:0] value);
            t_column_result r;
            int             n;
            longint         sum;
            case (cmd)
                CMD_MAT_WR: matrix[row][col] = value;
                CMD_VEC_WR: vector[row] = value;
                CMD_COMPUTE: begin
                    computes++;
                    n = (size_in_use > MAX_SIZE) ? MAX_SIZE : size_in_use;
                    for (int c = 0; c < n; c++) begin
                        sum = 0;
                        for (int j = 0; j < n; j++)
                            sum += longint'(vector[j]) * longint'(matrix[j][c]);
                        r.column  = c[COL_W-1:0];
                        r.product = sum[ACC_W-1:0];
                        r.last    = (c == n - 1);
                        awaited.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [COL_W-1:0] column,
                                 logic signed [ACC_W-1:0] product, logic last);
            t_column_result r;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result word: column %0d value %0d last %0b",
                         $time, column, product, last);
                errors++;
                return;
            end
            r = awaited.pop_front();
            columns_checked++;
            if (column !== r.column) begin
                $display("%0t: column index mismatch: expected %0d, actual %0d",
                         $time, r.column, column);
                errors++;
            end
            if (product !== r.product) begin
                $display("%0t: value mismatch on column %0d: expected %0d, actual %0d",
                         $time, r.column, r.product, product);
                errors++;
            end
            if (last !== r.last) begin
                $display("%0t: last mismatch on column %0d: expected %0b, actual %0b",
                         $time, r.column, r.last, last);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [CMD_W-1:0]          i_command = CMD_UNUSED;
    logic [FIELD_IDX_W-1:0]    i_row_index = '0;
    logic [FIELD_IDX_W-1:0]    i_col_index = '0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_W-1:0]          i_cfg_wdata = '0;
    logic                      o_result_strobe;
    logic [COL_W-1:0]          o_column_index;
    logic signed [ACC_W-1:0]   o_result_value;
    logic                      o_last;

    product_ledger ledger = new();
    int            words_sent = 0;
    bit            gaps_on = 1'b0;

    vector_matrix_multiply dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_value         (i_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_strobe (o_result_strobe),
        .o_column_index  (o_column_index),
        .o_result_value  (o_result_value),
        .o_last          (o_last)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe)
            ledger.check_word(o_column_index, o_result_value, o_last);
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            default: return VALUE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Presents one word and returns at the edge that takes it; start stays
    // high unless a gap follows.
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [FIELD_IDX_W-1:0] row,
                             logic [FIELD_IDX_W-1:0] col,
                             logic signed [VALUE_W-1:0] value);
        start       <= 1'b1;
        i_command   <= cmd;
        i_row_index <= row;
        i_col_index <= col;
        i_value     <= value;
        do @(posedge i_clk); while (busy);
        ledger.note_word(cmd, row, col, value);
        if (cmd != CMD_UNUSED)
            words_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // Holds off until every awaited result has arrived and the block has
    // settled, since a compute of size zero leaves nothing to wait for.
    task automatic wait_quiet();
        start <= 1'b0;
        do @(posedge i_clk); while (ledger.outstanding() != 0 || busy);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(int value);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ledger.set_size(value);
    endtask

    initial begin
        int sizes [] = '{2, 3, 1, 4, 5, 7, 0, 8, 32, 6, 3, 2, 16, 4, 63, 1, 5};
        int span;
        int phase_words;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on a single entry: sign extremes, zero and minus one.
        write_size(1);
        send_word(CMD_MAT_WR, 5'd0, 5'd0, 16'sh8000);
        send_word(CMD_VEC_WR, 5'd0, 5'd31, 16'sh8000);
        send_word(CMD_COMPUTE, 5'd0, 5'd0, '0);
        send_word(CMD_MAT_WR, 5'd0, 5'd0, 16'sh7fff);
        send_word(CMD_COMPUTE, 5'd31, 5'd31, 16'shffff);
        send_word(CMD_VEC_WR, 5'd0, 5'd0, 16'sh7fff);
        send_word(CMD_COMPUTE, 5'd0, 5'd0, '0);
        send_word(CMD_MAT_WR, 5'd0, 5'd0, '0);
        send_word(CMD_COMPUTE, 5'd0, 5'd0, '0);
        send_word(CMD_MAT_WR, 5'd0, 5'd0, 16'shffff);
        send_word(CMD_VEC_WR, 5'd0, 5'd0, 16'shffff);
        send_word(CMD_COMPUTE, 5'd0, 5'd0, '0);
        send_word(CMD_UNUSED, 5'd31, 5'd31, 16'shffff);
        send_word(CMD_MAT_WR, 5'd31, 5'd31, 16'sh7fff);
        send_word(CMD_VEC_WR, 5'd31, 5'd0, 16'sh8000);
        send_word(CMD_COMPUTE, 5'd0, 5'd0, '0);
        write_size(0);
        send_word(CMD_COMPUTE, 5'd0, 5'd0, '0);

        // Fill every entry with the most negative value so that a full-size
        // compute reaches the largest sum the accumulator ever holds.
        gaps_on = 1'b1;
        for (int r = 0; r < MAX_SIZE; r++) begin
            for (int c = 0; c < MAX_SIZE; c++)
                send_word(CMD_MAT_WR, r[4:0], c[4:0], 16'sh8000);
            send_word(CMD_VEC_WR, r[4:0], 5'd0, 16'sh8000);
        end
        write_size(32);
        send_word(CMD_COMPUTE, 5'd0, 5'd0, '0);
        for (int r = 0; r < MAX_SIZE; r++)
            send_word(CMD_VEC_WR, r[4:0], FIELD_IDX_W'($urandom_range(0, 31)), 16'sh7fff);
        // A size above the maximum is capped, giving the most negative sums.
        write_size(63);
        send_word(CMD_COMPUTE, 5'd0, 5'd0, '0);

        words_sent = 0;
        foreach (sizes[p]) begin
            write_size(sizes[p]);
            gaps_on     = (p < sizes.size() - 2) && ($urandom_range(0, 2) != 0);
            span        = (sizes[p] > MAX_SIZE) ? MAX_SIZE : sizes[p];
            phase_words = words_sent + 30;
            while (words_sent < phase_words) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: begin
                        // Well-formed: a few entries inside the size, then a compute.
                        repeat ($urandom_range(0, 4)) begin
                            if (span == 0)
                                send_word(CMD_W'($urandom_range(0, 1)),
                                          FIELD_IDX_W'($urandom_range(0, 31)),
                                          FIELD_IDX_W'($urandom_range(0, 31)),
                                          pick_value());
                            else if ($urandom_range(0, 2) == 0)
                                send_word(CMD_VEC_WR,
                                          FIELD_IDX_W'($urandom_range(0, span - 1)),
                                          FIELD_IDX_W'($urandom_range(0, 31)),
                                          pick_value());
                            else
                                send_word(CMD_MAT_WR,
                                          FIELD_IDX_W'($urandom_range(0, span - 1)),
                                          FIELD_IDX_W'($urandom_range(0, span - 1)),
                                          pick_value());
                        end
                        send_word(CMD_COMPUTE, FIELD_IDX_W'($urandom_range(0, 31)),
                                  FIELD_IDX_W'($urandom_range(0, 31)), pick_value());
                    end
                    7, 8:
                        send_word(CMD_W'($urandom_range(0, 1)),
                                  FIELD_IDX_W'($urandom_range(0, 31)),
                                  FIELD_IDX_W'($urandom_range(0, 31)), pick_value());
                    default:
                        send_word(CMD_UNUSED, FIELD_IDX_W'($urandom_range(0, 31)),
                                  FIELD_IDX_W'($urandom_range(0, 31)), pick_value());
                endcase
            end
        end

        wait_quiet();
        if (ledger.outstanding() != 0) begin
            $display("%0t: %0d result words never arrived", $time, ledger.outstanding());
            ledger.errors++;
        end
        $display("Ran %0d computes at sizes 0 to 63 with sign extremes and random entries;",
                 ledger.computes);
        $display("%0d column result words were compared.", ledger.columns_checked);
        if (ledger.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
